### rtl/core/sfc_pkg.sv
// Shared types and constants for the slab free checker.
// Request and result payloads, divider result, status and command codes.
// No dependencies.
`timescale 1ns / 1ps

package sfc_pkg;

  // Field widths
  localparam int ADDR_BITS = 64;
  localparam int SIZE_BITS = 17;
  localparam int COUNT_BITS = 7;
  localparam int SLAB_BITS = 4;
  localparam int STATUS_BITS = 2;
  localparam int CFG_BITS = 17;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_UNALIGNED = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_DUP_FREE  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_SLOT_SIZE    = 1'b0;
  localparam logic CFG_SLOTS_IN_USE = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [SLAB_BITS-1:0] slab_id;
    logic [ADDR_BITS-1:0] slab_base;
    logic [ADDR_BITS-1:0] item_addr;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ADDR_BITS-1:0]   slot_index;
    logic [ADDR_BITS-1:0]   expected_addr;
  } result_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] quotient;
    logic [SIZE_BITS-1:0] remainder;
  } div_result_t;

endpackage

### rtl/core/slab_free_checker.sv
// Slab free checker top level: sequencer, slot mark memory and result register.
// Depends on sfc_pkg, sfc_div and sfc_ram.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Its one result
// appears on result with done high for exactly one cycle. Nothing can hold
// the result off. busy falls as done rises, so the next request can be taken
// at the edge that takes the result. The divider loads at the transfer, then
// produces one quotient bit a cycle until the whole quotient is formed. After
// that the sequencer takes its done flag in S_DIV, forms the slot address and
// reads the mark memory in S_ADDR, and checks, updates the mark and registers
// the result in S_CHECK. After reset the block clears the mark memory one
// entry a cycle, all NUM_SLABS * MAX_SLOTS entries (1024 with the default
// sizes), and busy stays high meanwhile. Configuration writes are taken at
// any time but are meant only while the block is idle.
module slab_free_checker
  import sfc_pkg::*;
#(
  parameter int NUM_SLABS = 16,
  parameter int MAX_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                req,
  output logic                done,
  output result_t             result,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int DEPTH  = NUM_SLABS * MAX_SLOTS;
  localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_ADDR  = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [SIZE_BITS-1:0]  slot_size;
  logic [COUNT_BITS-1:0] slots_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_size    <= SIZE_BITS'(16);
      slots_in_use <= COUNT_BITS'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_SIZE:    slot_size    <= cfg_wdata[SIZE_BITS-1:0];
        CFG_SLOTS_IN_USE: slots_in_use <= cfg_wdata[COUNT_BITS-1:0];
        default:          ;
      endcase
    end
  end

  logic accept;
  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // Held request
  req_t req_q;
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // Shared divider
  logic        div_done;
  div_result_t div_res;

  sfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (req.item_addr - req.slab_base),
    .divisor  (slot_size),
    .done     (div_done),
    .res      (div_res)
  );

  // Range test and slot address, formed while the quotient is stable
  logic [ADDR_BITS-1:0] limit;
  logic                 slab_ok;
  logic                 slot_ok;
  logic [MEM_AW-1:0]    slot_addr;

  always_comb begin
    limit = (64'(slots_in_use) < 64'(MAX_SLOTS)) ? 64'(slots_in_use) : 64'(MAX_SLOTS);
    slab_ok = {{(32-SLAB_BITS){1'b0}}, req_q.slab_id} < 32'(NUM_SLABS);
    slot_ok = div_res.quotient < limit;
    slot_addr = MEM_AW'(req_q.slab_id) * MEM_AW'(MAX_SLOTS)
              + MEM_AW'(div_res.quotient[SLOT_W-1:0]);
  end

  logic                 in_range;
  logic                 aligned;
  logic [ADDR_BITS-1:0] expected;
  logic [MEM_AW-1:0]    addr_q;

  // expected = q * size + base equals item - remainder; a zero size gives base
  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      in_range <= slab_ok && slot_ok;
      aligned  <= (div_res.remainder == '0);
      expected <= (slot_size == '0) ? req_q.slab_base
                : req_q.item_addr - ADDR_BITS'(div_res.remainder);
      addr_q   <= slot_addr;
    end
  end

  // Clearing pass counter
  logic [MEM_AW-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + MEM_AW'(1);
    end
  end

  // Check and mark update
  logic                   mark;
  logic                   chk_we;
  logic                   chk_wdata;
  logic [STATUS_BITS-1:0] chk_status;

  always_comb begin
    chk_we     = 1'b0;
    chk_wdata  = 1'b0;
    chk_status = ST_OK;
    priority if (!in_range) begin
      chk_status = ST_RANGE;
    end else if (req_q.cmd == CMD_ALLOC) begin
      chk_we    = 1'b1;
      chk_wdata = 1'b1;
    end else if (!aligned) begin
      chk_status = ST_UNALIGNED;
    end else if (!mark) begin
      chk_status = ST_DUP_FREE;
    end else begin
      chk_we = 1'b1;
    end
  end

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic              ram_wdata;

  assign ram_we    = (state == S_CLEAR) || ((state == S_CHECK) && chk_we);
  assign ram_waddr = (state == S_CLEAR) ? clr_cnt : addr_q;
  assign ram_wdata = (state == S_CLEAR) ? 1'b0 : chk_wdata;

  sfc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH),
    .AW    (MEM_AW)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_addr),
    .rdata (mark)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == MEM_AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_ADDR;
      S_ADDR:  state_next = S_CHECK;
      S_CHECK: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_CHECK);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      result.status        <= chk_status;
      result.slot_index    <= div_res.quotient;
      result.expected_addr <= expected;
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not hold the block busy");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_mark_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("mark memory written outside clear or check");
`endif

endmodule

### rtl/core/sfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sfc_div.sv
// Restoring divider: 64-bit dividend by 17-bit divisor, one quotient bit per cycle.
// Depends on sfc_pkg.
`timescale 1ns / 1ps

module sfc_div
  import sfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ADDR_BITS-1:0] dividend,
  input  logic [SIZE_BITS-1:0] divisor,
  output logic                 done,
  output div_result_t          res
);

  localparam int STEP_W = $clog2(ADDR_BITS);

  logic                 active;
  logic [STEP_W-1:0]    step;
  logic [ADDR_BITS-1:0] quo;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] dvs;

  logic [SIZE_BITS:0]   rem_shift;
  logic [SIZE_BITS:0]   diff;
  logic                 ge;
  logic [SIZE_BITS-1:0] rem_next;
  logic [ADDR_BITS-1:0] quo_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem, quo[ADDR_BITS-1]};
    diff      = rem_shift - {1'b0, dvs};
    ge        = rem_shift >= {1'b0, dvs};
    rem_next  = ge ? diff[SIZE_BITS-1:0] : rem_shift[SIZE_BITS-1:0];
    quo_next  = {quo[ADDR_BITS-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(ADDR_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

### tb/slab_free_checker_chk.sv
// Scoreboard for the slab free checker: watches the request, result and register ports.
// Keeps its own slot allocation map and register copies and predicts each result.
// Depends on sfc_pkg.
`timescale 1ns / 1ps

module slab_free_checker_chk
  import sfc_pkg::*;
#(
  parameter int NUM_SLABS = 16,
  parameter int MAX_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  req_t                req,
  input  logic                done,
  input  result_t             result,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  outstanding,
  output int                  checked_count
);

  // Local copy of the block's state
  logic [SIZE_BITS-1:0]  div_size;
  logic [COUNT_BITS-1:0] slot_count;
  logic                  alloc_map [NUM_SLABS*MAX_SLOTS];

  // Verdicts waiting for their result transfer, oldest first
  result_t awaited_verdicts [$];
  int      shown;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    checked_count = 0;
    shown         = 0;
  end

  // Works out the verdict for one request and applies it to the allocation map
  task automatic compute_slot_status(input req_t r, output result_t v);
    logic [ADDR_BITS-1:0] offset;
    logic [ADDR_BITS-1:0] quot;
    logic [ADDR_BITS-1:0] divisor;
    logic [ADDR_BITS-1:0] limit;
    int                   pos;
    offset  = r.item_addr - r.slab_base;
    divisor = ADDR_BITS'(div_size);
    // zero size gives an all-ones index, always out of range
    quot    = (div_size == '0) ? '1 : offset / divisor;
    limit   = (int'(slot_count) < MAX_SLOTS) ? ADDR_BITS'(slot_count) : ADDR_BITS'(MAX_SLOTS);
    v.slot_index    = quot;
    v.expected_addr = quot * divisor + r.slab_base;
    v.status        = ST_OK;
    if (int'(r.slab_id) >= NUM_SLABS || quot >= limit) begin
      v.status = ST_RANGE;
    end else begin
      pos = int'(r.slab_id) * MAX_SLOTS + int'(quot);
      if (r.cmd == CMD_ALLOC) begin
        alloc_map[pos] = 1'b1;
      end else if (v.expected_addr != r.item_addr) begin
        v.status = ST_UNALIGNED;
      end else if (!alloc_map[pos]) begin
        v.status = ST_DUP_FREE;
      end else begin
        alloc_map[pos] = 1'b0;
      end
    end
  endtask

  // Sample every port at the rising edge, before the edge's own updates land
  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    int      fails;
    int      checks;
    fails  = fail_count;
    checks = checked_count;
    if (rst) begin
      div_size   = SIZE_BITS'(16);
      slot_count = COUNT_BITS'(64);
      for (int i = 0; i < NUM_SLABS * MAX_SLOTS; i++) alloc_map[i] = 1'b0;
      awaited_verdicts.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_SLOT_SIZE) div_size = cfg_wdata[SIZE_BITS-1:0];
        else                            slot_count = cfg_wdata[COUNT_BITS-1:0];
      end
      // result transfer against the oldest verdict
      if (done) begin
        if (awaited_verdicts.size() == 0) begin
          fails++;
          if (shown < 10) begin
            $display("%0t: result with nothing awaited: status %0d idx %h addr %h",
                     $time, result.status, result.slot_index, result.expected_addr);
            shown++;
          end
        end else begin
          want = awaited_verdicts.pop_front();
          checks++;
          if (result.status != want.status || result.slot_index != want.slot_index ||
              result.expected_addr != want.expected_addr) begin
            fails++;
            if (shown < 10) begin
              $display("%0t: mismatch: exp status %0d idx %h addr %h, got status %0d idx %h addr %h",
                       $time, want.status, want.slot_index, want.expected_addr,
                       result.status, result.slot_index, result.expected_addr);
              shown++;
            end
          end
        end
      end
      // request transfer
      if (start && !busy) begin
        compute_slot_status(req, fresh);
        awaited_verdicts.push_back(fresh);
      end
    end
    fail_count    <= fails;
    checked_count <= checks;
    outstanding   <= awaited_verdicts.size();
  end

endmodule

### tb/tb_slab_free_checker.sv
// Top of the slab free checker testbench: clock, reset, requests and register writes.
// Directed corner cases, then random phases over several register settings and idle rates.
// Depends on sfc_pkg, slab_free_checker and slab_free_checker_chk.
`timescale 1ns / 1ps

module tb_slab_free_checker;
  import sfc_pkg::*;

  localparam int LIMIT_CYCLES = 800000;
  localparam logic [63:0] TOP_BASE = 64'hFFFF_FFFF_FFFF_FF80;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  req_t                req = '0;
  logic                done;
  result_t             result;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_SLOT_SIZE;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int checked_count;

  // Generator view of the registers, used only to shape the stimulus
  int unsigned cur_size = 16;
  int unsigned cur_count = 64;
  int unsigned idle_pct = 0;
  logic [63:0] slab_bases [16];
  int          sent = 0;
  int          settings = 0;
  int unsigned cycles = 0;

  slab_free_checker dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  slab_free_checker_chk chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .done          (done),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic req_t mk(logic c, logic [3:0] s, logic [63:0] b, logic [63:0] a);
    req_t r;
    r.cmd       = c;
    r.slab_id   = s;
    r.slab_base = b;
    r.item_addr = a;
    return r;
  endfunction

  // Mostly aligned in-range traffic on a few slots per slab, plus unaligned,
  // out-of-range, wrapped and fully random requests
  function automatic req_t rand_req();
    req_t        r;
    logic [63:0] base;
    logic [63:0] item;
    logic [63:0] idx;
    logic [63:0] step;
    int unsigned lim;
    int unsigned span;
    int unsigned kind;
    r.cmd     = 1'($urandom_range(0, 1));
    r.slab_id = 4'($urandom_range(0, 15));
    base = slab_bases[r.slab_id];
    step = 64'(cur_size);
    lim  = (cur_count > 64) ? 64 : cur_count;
    if (lim == 0)                        span = 1;
    else if ($urandom_range(0, 7) == 0) span = lim;
    else                                 span = (lim < 8) ? lim : 8;
    idx  = 64'($urandom_range(0, span - 1));
    kind = $urandom_range(0, 99);
    if (kind < 62) begin
      item = base + idx * step;
    end else if (kind < 77) begin
      item = base + idx * step + 64'((cur_size > 1) ? $urandom_range(1, cur_size - 1) : 1);
    end else if (kind < 90) begin
      if ($urandom_range(0, 3) == 0) item = base - 64'($urandom_range(1, 4096));
      else item = base + (64'(lim) + 64'($urandom_range(0, 3))) * step;
    end else begin
      base = {$urandom, $urandom};
      item = {$urandom, $urandom};
    end
    r.slab_base = base;
    r.item_addr = item;
    return r;
  endfunction

  // One request transfer; called just after a rising edge
  task automatic send(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Sender gap after a transfer, at the phase's idle rate
  task automatic idle_gap();
    int unsigned gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 140) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every result is in and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_cfg(input int unsigned size, input int unsigned count);
    settle();
    write_reg(CFG_SLOT_SIZE, CFG_BITS'(size));
    @(posedge clk);
    write_reg(CFG_SLOTS_IN_USE, CFG_BITS'(count));
    @(posedge clk);
    cur_size  = size;
    cur_count = count;
    settings++;
  endtask

  int unsigned ph_size  [8];
  int unsigned ph_count [8];
  int unsigned ph_idle  [8];
  int unsigned ph_items [8];

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    settings = 1;

    // Directed: reset setting of 16-byte slots, 64 per slab
    send(mk(CMD_ALLOC, 4'd0, 64'd0, 64'd0));
    send(mk(CMD_FREE, 4'd0, 64'd0, 64'd0));
    send(mk(CMD_FREE, 4'd0, 64'd0, 64'd0));              // duplicate free
    send(mk(CMD_FREE, 4'd0, 64'd0, 64'd1));              // unaligned
    send(mk(CMD_ALLOC, 4'd15, TOP_BASE, TOP_BASE + 64'd1008)); // last slot, address wraps
    send(mk(CMD_ALLOC, 4'd15, TOP_BASE, TOP_BASE + 64'd1008)); // already marked
    send(mk(CMD_FREE, 4'd15, TOP_BASE, TOP_BASE + 64'd1008));
    send(mk(CMD_ALLOC, 4'd7, 64'h1000, 64'h1400));       // first index past the end
    send(mk(CMD_FREE, 4'd7, 64'h1000, 64'h1400));
    send(mk(CMD_FREE, 4'd7, 64'h1000, 64'h0FF0));        // item below base
    send(mk(CMD_ALLOC, 4'd3, '1, '1));
    send(mk(CMD_FREE, 4'd3, '1, '1));
    send(mk(CMD_FREE, 4'd8, 64'd0, '1));
    send(mk(CMD_FREE, 4'd9, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    // zero slot size
    apply_cfg(0, 64);
    send(mk(CMD_ALLOC, 4'd2, 64'h2000, 64'h2000));
    send(mk(CMD_FREE, 4'd2, 64'h2000, 64'h2010));
    // zero slot count
    apply_cfg(1, 0);
    send(mk(CMD_ALLOC, 4'd4, 64'd0, 64'd0));
    send(mk(CMD_FREE, 4'd4, 64'd0, 64'd5));
    // largest power-of-two size, count above the slot maximum
    apply_cfg(65536, 127);
    send(mk(CMD_ALLOC, 4'd5, 64'h100, 64'h100 + 64'd63 * 64'd65536));
    send(mk(CMD_FREE, 4'd5, 64'h100, 64'h100 + 64'd63 * 64'd65536));
    send(mk(CMD_ALLOC, 4'd5, 64'h100, 64'h100 + 64'd64 * 64'd65536));
    send(mk(CMD_FREE, 4'd5, 64'h100, 64'h100 + 64'd62 * 64'd65536 + 64'd65535));

    // Random phases
    ph_size  = '{16, 1, 65536, 131071, $urandom_range(1, 300), $urandom_range(0, 131071), 24, 0};
    ph_count = '{64, 8, 64, 127, $urandom_range(1, 64), $urandom_range(0, 127), 1, 64};
    ph_idle  = '{0, 78, 29, 0, 78, 29, 78, 0};
    ph_items = '{90, 90, 90, 90, 90, 90, 90, 30};
    for (int p = 0; p < 8; p++) begin
      apply_cfg(ph_size[p], ph_count[p]);
      idle_pct = ph_idle[p];
      for (int s = 0; s < 16; s++) slab_bases[s] = {$urandom, $urandom};
      slab_bases[15] = '1 - 64'($urandom_range(0, 2000));
      for (int n = 0; n < ph_items[p]; n++) begin
        send(rand_req());
        idle_gap();
      end
    end

    settle();
    $display("tb: %0d requests over %0d register settings, %0d results compared, %0d bad",
             sent, settings, checked_count, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
